>>> rtl/sdwk_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the swerve wheel kinematics.
// Used by the controller, the datapath and the top level; depends on nothing else.
package sdwk_pkg;

  localparam int WHEEL_COUNT          = 4;
  localparam int WHEEL_W              = 2;
  localparam int STEP_W               = 5;   // covers up to 24 CORDIC steps
  localparam int CORDIC_STEPS_DEFAULT = 16;

  localparam int VEC_W  = 30;  // Q8.16 vectors with headroom for CORDIC growth
  localparam int ANG_W  = 28;  // Q.24 CORDIC angle accumulator
  localparam int TGT_W  = 28;  // Q4.12 targets and chained heading
  localparam int WA_W   = 24;  // stored wheel angle, Q12.12
  localparam int MUL_A_W = 31;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int PI12      = 12868;
  localparam int HALF_PI12 = 6434;
  localparam int TWO_PI12  = 25736;
  localparam int ARC270_12 = 19302;
  localparam int UNWRAP12  = 25723;
  localparam int PI24      = 52707179;
  localparam int GAIN_Q16  = 39797;
  localparam int BRAKE_Q8  = 2560;
  localparam int ANG_MAX   = 8388607;
  localparam int ANG_MIN   = -8388608;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_ORIENTED     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_TO_BACK      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_TO_RIGHT      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN_RATE      = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GEAR_RATIO   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_SIGN_MASK = 8'd5;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MULX, OP_MULTX, OP_MULTY, OP_ROT_INIT, OP_ROT_ITER,
    OP_SAVE, OP_VEC_INIT, OP_VEC_ITER, OP_MAG, OP_ARC, OP_STEER
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MULX, ST_MULTX, ST_MULTY, ST_ROT_INIT, ST_ROT, ST_SAVE,
    ST_VEC_INIT, ST_VEC, ST_MAG, ST_ARC, ST_STEER, ST_OUT
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [STEP_W-1:0]  step;
    logic [WHEEL_W-1:0] wheel;
  } cmd_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_wr_t;

  function automatic logic signed [ANG_W-1:0] atan_q24(input logic [STEP_W-1:0] step);
    logic signed [ANG_W-1:0] v;
    case (step)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/swerve_drive_wheel_kinematics.sv
// Top level of the four-wheel swerve inverse kinematics block.
// Instantiates sdwk_controller and sdwk_datapath; depends on sdwk_pkg.
//
// Usage:
//  - Slave stream: one chassis request per handshake. s_tdata holds, from bit 0 up,
//    chassis_speed, chassis_heading, turn_rate, measured_yaw; s_tuser[0] is brake_request.
//  - Master stream: four results per request, wheels 0..3 in order; m_tlast marks wheel 3.
//  - Config channel: cfg_index selects a register, cfg_data carries its value; always ready.
//    Write only while no request is in work.
//  - Timing: a request is accepted only when the block is idle. It then runs the load,
//    three multiplies, rotation init, the CORDIC_STEPS rotation iterations and the save,
//    and per wheel the vectoring init, CORDIC_STEPS vectoring iterations, magnitude,
//    minor-arc and steer steps and an output step. The single shared CORDIC stage runs
//    one iteration per cycle.
//  - A stalled master holds the current result in the output register and freezes
//    the sequence until it is taken.
//  - Reset (rst, synchronous): config registers go to their defaults, stored wheel angles
//    to zero, the sequencer to idle.
module swerve_drive_wheel_kinematics #(
  parameter int CORDIC_STEPS = sdwk_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // chassis_speed, chassis_heading, turn_rate, measured_yaw
  input  logic [0:0]  s_tuser,   // brake_request
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // steer_position, drive_speed
  output logic [2:0]  m_tuser,   // wheel_number[1:0], brake_active
  output logic        m_tlast,   // last_wheel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sdwk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdwk_pkg::CFG_DAT_W-1:0] cfg_data
);
  import sdwk_pkg::*;

  cmd_t    cmd;
  cfg_wr_t cfg;

  // configuration never stalls
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  sdwk_controller #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  sdwk_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cfg     (cfg),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

>>> rtl/sdwk_datapath.sv
// Datapath: config registers, shared CORDIC iteration unit, shared multiplier,
// minor-arc rule, wheel angle store and output register. Depends on sdwk_pkg.
module sdwk_datapath (
  input  logic             clk,
  input  logic             rst,
  input  sdwk_pkg::cmd_t   cmd,
  input  sdwk_pkg::cfg_wr_t cfg,
  input  logic [63:0]      s_tdata,
  input  logic [0:0]       s_tuser,
  output logic [47:0]      m_tdata,
  output logic [2:0]       m_tuser,
  output logic             m_tlast
);
  import sdwk_pkg::*;

  logic        field_oriented;
  logic [15:0] front_to_back, left_to_right, steer_gear_ratio;
  logic [14:0] max_turn_rate;
  logic [7:0]  rotation_sign_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_oriented     <= 1'b0;
      front_to_back      <= 16'd256;
      left_to_right      <= 16'd256;
      max_turn_rate      <= 15'd1024;
      steer_gear_ratio   <= 16'd256;
      rotation_sign_mask <= 8'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FIELD_ORIENTED:     field_oriented     <= cfg.data[0];
        CFG_FRONT_TO_BACK:      front_to_back      <= cfg.data;
        CFG_LEFT_TO_RIGHT:      left_to_right      <= cfg.data;
        CFG_MAX_TURN_RATE:      max_turn_rate      <= cfg.data[14:0];
        CFG_STEER_GEAR_RATIO:   steer_gear_ratio   <= cfg.data;
        CFG_ROTATION_SIGN_MASK: rotation_sign_mask <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // working registers
  logic signed [15:0]      speed_r, omega_r;
  logic                    brake_r, moving_r;
  logic signed [TGT_W-1:0] dir_r, target_r;
  logic signed [VEC_W-1:0] x, y, vx, vy, tx, ty;
  logic signed [ANG_W-1:0] z;
  logic signed [23:0]      drive_r;
  logic signed [WA_W-1:0]  wheel_angle [WHEEL_COUNT];

  // command load: heading correction and turn rate clamp
  logic signed [15:0] in_speed, in_heading, in_turn, in_yaw;
  logic signed [17:0] yaw_off, yaw_off_w;
  logic signed [18:0] dir_load;
  logic signed [16:0] lim, om17, om_cl;

  assign in_speed   = s_tdata[15:0];
  assign in_heading = s_tdata[31:16];
  assign in_turn    = s_tdata[47:32];
  assign in_yaw     = s_tdata[63:48];

  always_comb begin
    yaw_off   = 18'(in_yaw) - 18'(HALF_PI12);
    yaw_off_w = (yaw_off > PI12) ? yaw_off - 18'(TWO_PI12) : yaw_off;
    dir_load  = field_oriented ? 19'(in_heading) - 19'(yaw_off_w) : 19'(in_heading);
    lim       = {2'b00, max_turn_rate};
    om17      = 17'(in_turn);
    om_cl     = (om17 > lim) ? lim : ((om17 < -lim) ? -lim : om17);
  end

  // rotation init: reduce heading into [-pi, pi], fold into right half plane
  logic signed [TGT_W-1:0] red [5];
  logic signed [TGT_W-1:0] a_fold;
  logic                    fold;
  always_comb begin
    red[0] = dir_r;
    for (int k = 0; k < 4; k++) begin
      if (red[k] > PI12)       red[k+1] = red[k] - TGT_W'(TWO_PI12);
      else if (red[k] < -PI12) red[k+1] = red[k] + TGT_W'(TWO_PI12);
      else                     red[k+1] = red[k];
    end
    fold   = 1'b0;
    a_fold = red[4];
    if (red[4] > HALF_PI12) begin
      fold = 1'b1; a_fold = red[4] - TGT_W'(PI12);
    end else if (red[4] < -HALF_PI12) begin
      fold = 1'b1; a_fold = red[4] + TGT_W'(PI12);
    end
  end

  // CORDIC iteration
  logic signed [VEC_W-1:0] xs, ys;
  logic signed [ANG_W-1:0] at;
  assign xs = x >>> cmd.step;
  assign ys = y >>> cmd.step;
  assign at = atan_q24(cmd.step);

  // polar init for the selected wheel
  logic signed [VEC_W-1:0] px, py;
  always_comb begin
    px = vx + (rotation_sign_mask[{cmd.wheel, 1'b0}] ? -tx : tx);
    py = vy + (rotation_sign_mask[{cmd.wheel, 1'b1}] ? -ty : ty);
  end

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod, mag_rnd;
  logic signed [PROD_W-1:0]  steer_sh;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MULX:  begin mul_a = MUL_A_W'(speed_r); mul_b = MUL_B_W'(GAIN_Q16); end
      OP_MULTX: begin mul_a = MUL_A_W'(omega_r); mul_b = MUL_B_W'({2'b00, front_to_back}); end
      OP_MULTY: begin mul_a = MUL_A_W'(omega_r); mul_b = MUL_B_W'({2'b00, left_to_right}); end
      OP_MAG:   begin mul_a = MUL_A_W'(x); mul_b = MUL_B_W'(GAIN_Q16); end
      OP_STEER: begin
        mul_a = MUL_A_W'(wheel_angle[cmd.wheel]);
        mul_b = MUL_B_W'({2'b00, steer_gear_ratio});
      end
      default: ;
    endcase
    prod     = mul_a * mul_b;
    mag_rnd  = (prod + PROD_W'(64'sd8388608)) >>> 24;
    steer_sh = prod >>> 8;
  end

  logic signed [TGT_W-1:0] ang_rnd;
  assign ang_rnd = TGT_W'((z + ANG_W'(2048)) >>> 12);

  // minor-arc rule against the stored angle
  logic signed [TGT_W-1:0] now_a, tgt_new;
  logic signed [TGT_W:0]   d, ad, d2;
  logic signed [23:0]      drv_new;
  logic signed [WA_W-1:0]  wa_new;
  always_comb begin
    now_a   = TGT_W'(wheel_angle[cmd.wheel]);
    d       = (TGT_W+1)'(target_r) - (TGT_W+1)'(now_a);
    ad      = (d < 0) ? -d : d;
    d2      = d;
    drv_new = drive_r;
    if (ad > HALF_PI12 && ad < ARC270_12) begin
      tgt_new = target_r + ((target_r < 0) ? TGT_W'(PI12) : -TGT_W'(PI12));
      drv_new = -drive_r;
    end else begin
      if (d > ARC270_12)       d2 = d - (TGT_W+1)'(UNWRAP12);
      else if (d < -ARC270_12) d2 = d + (TGT_W+1)'(UNWRAP12);
      tgt_new = TGT_W'((TGT_W+1)'(now_a) + d2);
    end
    if (tgt_new > ANG_MAX)      wa_new = WA_W'(ANG_MAX);
    else if (tgt_new < ANG_MIN) wa_new = WA_W'(ANG_MIN);
    else                        wa_new = WA_W'(tgt_new);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        speed_r <= in_speed;
        omega_r <= 16'(om_cl);
        dir_r   <= TGT_W'(dir_load);
        brake_r <= s_tuser[0];
      end
      OP_MULX: begin
        x        <= VEC_W'(prod >>> 8);
        moving_r <= (speed_r != 0) || (omega_r != 0);
      end
      OP_MULTX: tx <= VEC_W'(prod >>> 5);
      OP_MULTY: ty <= VEC_W'(prod >>> 5);
      OP_ROT_INIT: begin
        if (fold) x <= -x;
        y <= '0;
        z <= ANG_W'(a_fold) <<< 12;
      end
      OP_ROT_ITER: begin
        if (z >= 0) begin
          x <= x - ys; y <= y + xs; z <= z - at;
        end else begin
          x <= x + ys; y <= y - xs; z <= z + at;
        end
      end
      OP_SAVE: begin
        vx <= x;
        vy <= y;
      end
      OP_VEC_INIT: begin
        if (px < 0) begin
          x <= -px; y <= -py;
          z <= (py >= 0) ? ANG_W'(PI24) : -ANG_W'(PI24);
        end else begin
          x <= px; y <= py; z <= '0;
        end
      end
      OP_VEC_ITER: begin
        if (y > 0) begin
          x <= x + ys; y <= y - xs; z <= z + at;
        end else if (y < 0) begin
          x <= x - ys; y <= y + xs; z <= z - at;
        end
      end
      OP_MAG: begin
        if (moving_r) begin
          drive_r <= 24'(mag_rnd);
          if (ang_rnd > PI12)       target_r <= TGT_W'(PI12);
          else if (ang_rnd < -PI12) target_r <= -TGT_W'(PI12);
          else                      target_r <= ang_rnd;
        end else begin
          drive_r  <= '0;
          target_r <= dir_r;
        end
      end
      OP_ARC: begin
        drive_r <= moving_r ? drv_new : 24'sd0;
        if (!moving_r) dir_r <= tgt_new;
      end
      OP_STEER: begin
        m_tuser[1:0] <= cmd.wheel;
        m_tuser[2]   <= brake_r;
        m_tlast      <= (cmd.wheel == WHEEL_W'(WHEEL_COUNT - 1));
        if (steer_sh > 64'sd2147483647)       m_tdata[31:0] <= 32'h7FFF_FFFF;
        else if (steer_sh < -64'sd2147483648) m_tdata[31:0] <= 32'h8000_0000;
        else                                  m_tdata[31:0] <= 32'(steer_sh);
        if (brake_r)                 m_tdata[47:32] <= 16'(BRAKE_Q8);
        else if (drive_r > 32767)    m_tdata[47:32] <= 16'h7FFF;
        else if (drive_r < -32768)   m_tdata[47:32] <= 16'h8000;
        else                         m_tdata[47:32] <= 16'(drive_r);
      end
      default: ;
    endcase
  end

  // stored wheel angles
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WHEEL_COUNT; i++) wheel_angle[i] <= '0;
    end else if (cmd.op == OP_ARC) begin
      wheel_angle[cmd.wheel] <= wa_new;
    end
  end

endmodule

>>> rtl/sdwk_controller.sv
// Sequencer for one chassis command: load, multiplies, rotation CORDIC, then per wheel
// vectoring CORDIC, minor-arc rule and output handshake. Depends on sdwk_pkg.
module sdwk_controller #(
  parameter int CORDIC_STEPS = sdwk_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output sdwk_pkg::cmd_t cmd
);
  import sdwk_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [WHEEL_W-1:0] WHEEL_LAST = WHEEL_W'(WHEEL_COUNT - 1);

  state_t             state, state_next;
  logic [STEP_W-1:0]  step, step_next;
  logic [WHEEL_W-1:0] wheel, wheel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      wheel <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      wheel <= wheel_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    wheel_next = wheel;
    cmd.op     = OP_NONE;
    cmd.step   = step;
    cmd.wheel  = wheel;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_MULX;
        end
      end
      ST_MULX:  begin cmd.op = OP_MULX;  state_next = ST_MULTX; end
      ST_MULTX: begin cmd.op = OP_MULTX; state_next = ST_MULTY; end
      ST_MULTY: begin cmd.op = OP_MULTY; state_next = ST_ROT_INIT; end
      ST_ROT_INIT: begin
        cmd.op     = OP_ROT_INIT;
        step_next  = '0;
        state_next = ST_ROT;
      end
      ST_ROT: begin
        cmd.op = OP_ROT_ITER;
        if (step == STEP_LAST) state_next = ST_SAVE;
        else                   step_next  = step + 1'b1;
      end
      ST_SAVE: begin
        cmd.op     = OP_SAVE;
        wheel_next = '0;
        state_next = ST_VEC_INIT;
      end
      ST_VEC_INIT: begin
        cmd.op     = OP_VEC_INIT;
        step_next  = '0;
        state_next = ST_VEC;
      end
      ST_VEC: begin
        cmd.op = OP_VEC_ITER;
        if (step == STEP_LAST) state_next = ST_MAG;
        else                   step_next  = step + 1'b1;
      end
      ST_MAG:   begin cmd.op = OP_MAG;   state_next = ST_ARC; end
      ST_ARC:   begin cmd.op = OP_ARC;   state_next = ST_STEER; end
      ST_STEER: begin cmd.op = OP_STEER; state_next = ST_OUT; end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (wheel == WHEEL_LAST) begin
            state_next = ST_IDLE;
          end else begin
            wheel_next = wheel + 1'b1;
            state_next = ST_VEC_INIT;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (rst) step <= STEP_LAST)
    else $error("CORDIC step past last");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_MULX)
    else $error("accepted request did not start work");
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && wheel == WHEEL_LAST |=> state == ST_IDLE)
    else $error("last wheel did not return to idle");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && wheel != WHEEL_LAST |=> state == ST_VEC_INIT && step_next == '0)
    else $error("next wheel did not start");
`endif

endmodule

>>> tb/tb.sv
// Self-checking bench for swerve_drive_wheel_kinematics: random and directed chassis requests
// against a bit-exact wheel predictor, under several idling phases and register settings.
// Depends on sdwk_pkg and the RTL of the block only.
module tb;
  import sdwk_pkg::*;

  typedef struct packed {
    logic [1:0]  wheel;
    logic [31:0] steer;
    logic [15:0] drive;
    logic        brake;
    logic        last;
  } wheel_cmd_t;

  typedef struct packed {
    logic [15:0] yaw;
    logic [15:0] turn;
    logic [15:0] heading;
    logic [15:0] speed;
    logic        brake;
  } chassis_req_t;

  localparam int STEPS = CORDIC_STEPS_DEFAULT;
  localparam longint ARCTAN[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // chassis_speed, chassis_heading, turn_rate, measured_yaw
  logic [0:0]  s_tuser = '0;   // brake_request
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;        // steer_position, drive_speed
  logic [2:0]  m_tuser;        // wheel_number[1:0], brake_active
  logic        m_tlast;        // last_wheel
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  swerve_drive_wheel_kinematics DUT (.*);

  always #6 clk = ~clk;

  // Predictor copy of registers and stored wheel angles
  logic         abs_mode;
  longint       wheelbase, track, turn_limit, gear, sign_mask;
  longint       wheel_angle[4];

  chassis_req_t pending_reqs[$];
  wheel_cmd_t   expected_cmds[$];
  int           send_idle_pct = 0, recv_stall_pct = 0;
  bit           hold_sender = 0;
  bit           req_taken = 0;
  int           errors = 0, reqs_sent = 0, cmds_checked = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Rotate a Q8.8 speed by a Q4.12 angle into Q8.16 components
  task automatic spin(input longint speed, input longint a, output longint cx, output longint sy);
    longint x, y, z, nx, ny;
    x = (speed * GAIN_Q16) >>> 8;
    y = 0;
    for (int k = 0; k < 4; k++) begin
      if (a > PI12) a -= TWO_PI12;
      else if (a < -PI12) a += TWO_PI12;
    end
    if (a > HALF_PI12) begin
      a -= PI12; x = -x;
    end else if (a < -HALF_PI12) begin
      a += PI12; x = -x;
    end
    z = a * 4096;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN[i];
      end
      x = nx; y = ny;
    end
    cx = x; sy = y;
  endtask

  // Q8.16 vector to magnitude Q8.8 and angle Q4.12
  task automatic to_polar(input longint x, input longint y, output longint mag, output longint ang);
    longint z, nx, ny;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0; ang = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? PI24 : -longint'(PI24); x = -x; y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y != 0) begin
        if (y > 0) begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN[i];
        end else begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN[i];
        end
        x = nx; y = ny;
      end
    end
    mag = round_shr(x * GAIN_Q16, 24);
    ang = clip(round_shr(z, 12), -PI12, PI12);
  endtask

  // Shortest-turn rule: flip and reverse drive, or unwrap the change
  task automatic shortest_turn(input longint now, inout longint target, inout longint speed);
    longint d, ad;
    d = target - now;
    ad = d < 0 ? -d : d;
    if (ad > HALF_PI12 && ad < ARC270_12) begin
      target += (target < 0) ? PI12 : -PI12;
      speed = -speed;
    end else begin
      if (d > ARC270_12) d -= UNWRAP12;
      else if (d < -ARC270_12) d += UNWRAP12;
      target = now + d;
    end
  endtask

  task automatic predict_wheels(input chassis_req_t r);
    longint speed, dir, omega, yaw, off, vx, vy, tx, ty, sxv, syv, target, drive, steer;
    bit moving;
    wheel_cmd_t c;
    speed = longint'($signed(r.speed));
    dir   = longint'($signed(r.heading));
    omega = longint'($signed(r.turn));
    yaw   = longint'($signed(r.yaw));
    if (abs_mode) begin
      off = yaw - HALF_PI12;
      if (off > PI12) off -= TWO_PI12;
      dir -= off;
    end
    omega = clip(omega, -turn_limit, turn_limit);
    spin(speed, dir, vx, vy);
    tx = (omega * wheelbase) >>> 5;
    ty = (omega * track) >>> 5;
    moving = (speed != 0) || (omega != 0);
    for (int i = 0; i < 4; i++) begin
      if (moving) begin
        sxv = sign_mask[2*i]   ? -tx : tx;
        syv = sign_mask[2*i+1] ? -ty : ty;
        to_polar(vx + sxv, vy + syv, drive, target);
        shortest_turn(wheel_angle[i], target, drive);
      end else begin
        drive = 0;
        shortest_turn(wheel_angle[i], dir, drive);
        drive = 0;
        target = dir;
      end
      wheel_angle[i] = clip(target, ANG_MIN, ANG_MAX);
      steer = clip((wheel_angle[i] * gear) >>> 8, -64'sd2147483648, 64'sd2147483647);
      drive = r.brake ? BRAKE_Q8 : clip(drive, -32768, 32767);
      c.wheel = i[1:0];
      c.steer = steer[31:0];
      c.drive = drive[15:0];
      c.brake = r.brake;
      c.last  = (i == 3);
      expected_cmds.push_back(c);
    end
  endtask

  // Driver: advance the request stream at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!s_tvalid || req_taken) begin
        if (pending_reqs.size() > 0 && !hold_sender && $urandom_range(99) >= send_idle_pct) begin
          chassis_req_t r;
          r = pending_reqs.pop_front();
          s_tdata  <= {r.yaw, r.turn, r.heading, r.speed};
          s_tuser  <= r.brake;
          s_tvalid <= 1;
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // Monitor: predict on accepted requests, check accepted wheel commands
  always @(posedge clk) begin
    req_taken <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      predict_wheels({s_tdata[63:48], s_tdata[47:32], s_tdata[31:16], s_tdata[15:0], s_tuser[0]});
      reqs_sent++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cmds.size() == 0) begin
        $error("wheel command with nothing expected: %h", {m_tdata, m_tuser, m_tlast});
        errors++;
      end else begin
        wheel_cmd_t e;
        e = expected_cmds.pop_front();
        cmds_checked++;
        if (m_tuser[1:0] !== e.wheel) begin
          $error("wheel_number expected %0d got %0d", e.wheel, m_tuser[1:0]); errors++;
        end
        if (m_tdata[31:0] !== e.steer) begin
          $error("steer_position expected %0d got %0d", $signed(e.steer), $signed(m_tdata[31:0]));
          errors++;
        end
        if (m_tdata[47:32] !== e.drive) begin
          $error("drive_speed expected %0d got %0d", $signed(e.drive), $signed(m_tdata[47:32]));
          errors++;
        end
        if (m_tuser[2] !== e.brake) begin
          $error("brake_active expected %0d got %0d", e.brake, m_tuser[2]); errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last_wheel expected %0d got %0d", e.last, m_tlast); errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FIELD_ORIENTED:     abs_mode   = val[0];
      CFG_FRONT_TO_BACK:      wheelbase  = val & 16'hFFFF;
      CFG_LEFT_TO_RIGHT:      track      = val & 16'hFFFF;
      CFG_MAX_TURN_RATE:      turn_limit = val & 15'h7FFF;
      CFG_STEER_GEAR_RATIO:   gear       = val & 16'hFFFF;
      CFG_ROTATION_SIGN_MASK: sign_mask  = val & 8'hFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_all(input longint am, ftb, ltr, mtr, gr, mask);
    write_reg(CFG_FIELD_ORIENTED, am);
    write_reg(CFG_FRONT_TO_BACK, ftb);
    write_reg(CFG_LEFT_TO_RIGHT, ltr);
    write_reg(CFG_MAX_TURN_RATE, mtr);
    write_reg(CFG_STEER_GEAR_RATIO, gr);
    write_reg(CFG_ROTATION_SIGN_MASK, mask);
  endtask

  // Wait until every queued request is sent and every wheel command has come back
  task automatic drain();
    while (pending_reqs.size() > 0 || s_tvalid || expected_cmds.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_req(input int spd, hdg, trn, yw, input bit brk);
    chassis_req_t r;
    r.speed = spd[15:0]; r.heading = hdg[15:0]; r.turn = trn[15:0]; r.yaw = yw[15:0];
    r.brake = brk;
    pending_reqs.push_back(r);
  endtask

  // Mostly plausible chassis commands, some zero commands, some raw noise
  task automatic queue_random(input int n);
    int kind;
    repeat (n) begin
      kind = $urandom_range(9);
      if (kind == 0)
        queue_req(0, $urandom, 0, $urandom, $urandom_range(1));
      else if (kind <= 2)
        queue_req($urandom, $urandom, $urandom, $urandom, $urandom_range(1));
      else
        queue_req($urandom_range(1536) - 768, $urandom_range(2 * PI12) - PI12,
                  $urandom_range(8192) - 4096, $urandom_range(2 * PI12) - PI12,
                  $urandom_range(9) == 0);
    end
  endtask

  initial begin
    abs_mode = 0; wheelbase = 256; track = 256; turn_limit = 1024; gear = 256; sign_mask = 0;
    foreach (wheel_angle[i]) wheel_angle[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: reset settings, extremes, zero commands, flips, brake
    queue_req(0, 0, 0, 0, 0);
    queue_req(0, PI12, 0, 0, 0);                 // zero command chains heading
    queue_req(0, -PI12, 0, 0, 1);
    queue_req(256, 0, 0, 0, 0);
    queue_req(256, PI12, 0, 0, 0);               // reverse: flip and negate drive
    queue_req(256, HALF_PI12 + 10, 0, 0, 0);
    queue_req(-32768, -32768, -32768, -32768, 0);
    queue_req(32767, 32767, 32767, 32767, 1);
    queue_req(0, 0, 32767, 0, 0);                // turn rate clamped
    queue_req(0, 0, -32768, 0, 0);
    queue_req(-256, -HALF_PI12, 500, 0, 0);
    drain();
    set_all(1, 65535, 65535, 32767, 65535, 8'hFF);
    queue_req(32767, 0, 32767, 0, 0);            // saturated drive and steer
    queue_req(-32768, PI12, -32768, 32767, 0);
    queue_req(256, 0, 0, HALF_PI12, 0);
    queue_req(256, 0, 0, -32768, 1);
    queue_req(0, 32767, 0, 32767, 0);
    drain();
    set_all(0, 0, 0, 0, 0, 8'h55);               // zero gear ratio, no rotation
    queue_req(0, 0, 4096, 0, 0);
    queue_req(512, 1000, -4096, 0, 0);
    queue_req(0, -20000, 0, 0, 0);
    drain();

    // Random phases with different idling and settings
    set_all(0, 256, 256, 1024, 256, 0);
    queue_random(90);
    drain();
    send_idle_pct = 51;
    set_all(1, $urandom_range(65535), $urandom_range(65535), $urandom_range(32767),
            $urandom_range(65535, 1), $urandom_range(255));
    queue_random(90);
    drain();
    send_idle_pct = 0; recv_stall_pct = 51;
    set_all($urandom_range(1), 1, 65535, 32767, 1, 8'hAA);
    queue_random(45);
    // let part of the batch go out, then hold the sender until everything has come back
    while (pending_reqs.size() > 20) @(posedge clk);
    hold_sender = 1;
    while (expected_cmds.size() > 0 || s_tvalid) @(posedge clk);
    hold_sender = 0;
    queue_random(45);
    drain();
    send_idle_pct = 32; recv_stall_pct = 32;
    set_all(0, $urandom_range(2048), $urandom_range(2048), $urandom_range(32767),
            $urandom_range(2048, 1), $urandom_range(255));
    queue_random(90);
    drain();

    $display("Covered %0d chassis requests and %0d wheel commands over six register settings,",
             reqs_sent, cmds_checked);
    $display("with sender gaps, receiver stalls and a full drain hold.");
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
